// ===== src/pcc_pkg.sv =====
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int RESULT_CAP = 64;
    localparam int PAIR_CAP   = RESULT_CAP / 2;
    localparam int PAIR_AW    = $clog2(PAIR_CAP);
    localparam int PAIR_CW    = $clog2(PAIR_CAP + 1);
    localparam int OUT_IDX_W  = 6;
    localparam int RADIUS_W   = 16;
    localparam int LAYER_W    = 2;
    localparam int RSUM_W     = RADIUS_W + 1;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_CHECK   = 7'b0000010,
        ST_DRAIN   = 7'b0000100,
        ST_EMIT_RD = 7'b0001000,
        ST_EMIT_A  = 7'b0010000,
        ST_EMIT_B  = 7'b0100000,
        ST_NOHIT   = 7'b1000000
    } t_state;

endpackage

// ===== src/pcc_pair_test.sv =====
`timescale 1ns / 1ps

module pcc_pair_test
    import pcc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int TAG_W      = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic        [RADIUS_W-1:0]   i_ar,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic        [RADIUS_W-1:0]   i_br,
    input  logic        [TAG_W-1:0]      i_tag,
    output logic                         o_hit,
    output logic        [TAG_W-1:0]      o_tag,
    output logic                         o_busy
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 1;
    localparam int RSQ_W = 2 * RSUM_W;
    localparam int CMP_W = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;

    logic signed [COORD_BITS:0] ddx;
    logic signed [COORD_BITS:0] ddy;
    logic signed [COORD_BITS:0] adx;
    logic signed [COORD_BITS:0] ady;

    logic                  r_va;
    logic [COORD_BITS-1:0] r_dx;
    logic [COORD_BITS-1:0] r_dy;
    logic [RSUM_W-1:0]     r_rs;
    logic [TAG_W-1:0]      r_tag_a;

    logic              r_vb;
    logic [SQ_W-1:0]   r_dx2;
    logic [SQ_W-1:0]   r_dy2;
    logic [RSQ_W-1:0]  r_rs2;
    logic [TAG_W-1:0]  r_tag_b;

    logic [CMP_W-1:0] dist2;
    logic [CMP_W-1:0] lim2;

    always_comb begin
        ddx = {i_ax[COORD_BITS-1], i_ax} - {i_bx[COORD_BITS-1], i_bx};
        ddy = {i_ay[COORD_BITS-1], i_ay} - {i_by[COORD_BITS-1], i_by};
        adx = ddx[COORD_BITS] ? -ddx : ddx;
        ady = ddy[COORD_BITS] ? -ddy : ddy;
    end

    // stage a: magnitudes and radius sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
        r_dx    <= adx[COORD_BITS-1:0];
        r_dy    <= ady[COORD_BITS-1:0];
        r_rs    <= {1'b0, i_ar} + {1'b0, i_br};
        r_tag_a <= i_tag;
    end

    // stage b: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_dx2   <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_dy2   <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_rs2   <= RSQ_W'(r_rs) * RSQ_W'(r_rs);
        r_tag_b <= r_tag_a;
    end

    assign dist2  = CMP_W'(r_dx2) + CMP_W'(r_dy2);
    assign lim2   = CMP_W'(r_rs2);
    assign o_hit  = r_vb && (dist2 < lim2);
    assign o_tag  = r_tag_b;
    assign o_busy = r_va || r_vb;

endmodule

// ===== src/pairwise_circle_collision.sv =====
`timescale 1ns / 1ps

// Pairwise circle collision detector.
// Input channel: one circle per beat (center, radius, layer, frame_end), taken
// one per cycle while o_in_stall is low. Circles are stored in load order; those
// past MAX_CIRCLES in a frame are ignored. The beat with frame_end set starts the
// pair check and the input stalls until the frame's results are handed over.
// The check reads the circle memory once per cycle: one read per pair plus one
// per outer circle, then the compare pipeline drains. Hits are kept in a
// 32-entry pair memory. Output channel: each stored hit gives two beats (i,j)
// then (j,i); a frame with no hit gives one beat with hit low. dropped is
// set on every beat of a frame whose hits overflowed 64 results; last marks the
// final beat. The output register holds its beat while i_out_stall is high.
// layer_mask is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while the block is idle; the block itself does not enforce it.
// Reset clears the control state and layer_mask; memory contents are not
// cleared and no clearing pass runs.

module pairwise_circle_collision
    import pcc_pkg::*;
#(
    parameter int MAX_CIRCLES = 64,
    parameter int NUM_LAYERS  = 3,
    parameter int COORD_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [NUM_LAYERS*NUM_LAYERS-1:0]    i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [COORD_BITS-1:0]        i_center_x,
    input  logic signed [COORD_BITS-1:0]        i_center_y,
    input  logic [RADIUS_W-1:0]                 i_radius,
    input  logic [LAYER_W-1:0]                  i_layer,
    input  logic                                i_frame_end,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [OUT_IDX_W-1:0]                o_self_index,
    output logic [OUT_IDX_W-1:0]                o_other_index,
    output logic                                o_hit,
    output logic                                o_dropped,
    output logic                                o_last
);

    localparam int MASK_BITS = NUM_LAYERS * NUM_LAYERS;
    localparam int MIDX_W    = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;
    localparam int IDX_W     = $clog2(MAX_CIRCLES);
    localparam int CNT_W     = $clog2(MAX_CIRCLES + 1);
    localparam int TAG_W     = 2 * IDX_W;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [RADIUS_W-1:0]          r;
        logic [LAYER_W-1:0]           layer;
    } t_circle;

    t_circle    circ_mem [MAX_CIRCLES];
    logic [TAG_W-1:0] pair_mem [PAIR_CAP];

    t_state r_state;
    t_state n_state;

    logic [MASK_BITS-1:0] r_mask;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_n;
    logic [IDX_W-1:0]     r_ii;
    logic [CNT_W-1:0]     r_jj;
    logic                 r_piv;

    logic                 in_acc;
    logic [CNT_W-1:0]     cnt_next;
    logic [IDX_W-1:0]     rd_addr;
    logic                 issue;

    t_circle              r_rd_data;
    logic                 r_rd_v;
    logic                 r_rd_piv;
    logic [IDX_W-1:0]     r_rd_idx;
    t_circle              r_ci;
    logic [IDX_W-1:0]     r_ci_idx;

    logic                 lay_ok;
    logic [MIDX_W-1:0]    midx;
    logic                 allow;
    logic                 test_v;

    logic                 hit_v;
    logic [TAG_W-1:0]     hit_tag;
    logic                 pt_busy;

    logic [PAIR_CW-1:0]   r_np;
    logic                 r_drop_flag;
    logic [PAIR_CW-1:0]   r_k;
    logic [TAG_W-1:0]     r_prd;

    logic                 r_ovalid;
    logic [IDX_W-1:0]     r_self;
    logic [IDX_W-1:0]     r_other;
    logic                 r_ohit;
    logic                 r_odrop;
    logic                 r_olast;
    logic                 out_free;
    logic                 last_pair;

    logic [IDX_W+OUT_IDX_W-1:0] self_ext;
    logic [IDX_W+OUT_IDX_W-1:0] other_ext;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cnt_next   = (r_count < CNT_W'(MAX_CIRCLES)) ? r_count + 1'b1 : r_count;
    assign out_free   = !r_ovalid || !i_out_stall;
    assign last_pair  = (r_k + 1'b1 == r_np);

    // circle store: write on load, one read per cycle
    always_ff @(posedge i_clk) begin
        if (in_acc && r_count < CNT_W'(MAX_CIRCLES)) begin
            circ_mem[r_count[IDX_W-1:0]] <= '{x: i_center_x, y: i_center_y,
                                              r: i_radius, layer: i_layer};
        end
        r_rd_data <= circ_mem[rd_addr];
    end

    assign issue   = (r_state == ST_CHECK);
    assign rd_addr = r_piv ? r_ii : r_jj[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= issue;
        end
        r_rd_piv <= r_piv;
        r_rd_idx <= rd_addr;
    end

    // pivot beats load the outer circle; other beats test against it
    always_ff @(posedge i_clk) begin
        if (r_rd_v && r_rd_piv) begin
            r_ci     <= r_rd_data;
            r_ci_idx <= r_rd_idx;
        end
    end

    always_comb begin
        lay_ok = (int'(r_ci.layer) < NUM_LAYERS) && (int'(r_rd_data.layer) < NUM_LAYERS);
        midx   = MIDX_W'(int'(r_ci.layer) * NUM_LAYERS + int'(r_rd_data.layer));
        allow  = lay_ok ? r_mask[midx] : 1'b0;
        test_v = r_rd_v && !r_rd_piv && allow;
    end

    pcc_pair_test #(
        .COORD_BITS (COORD_BITS),
        .TAG_W      (TAG_W)
    ) u_pair_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (test_v),
        .i_ax    (r_ci.x),
        .i_ay    (r_ci.y),
        .i_ar    (r_ci.r),
        .i_bx    (r_rd_data.x),
        .i_by    (r_rd_data.y),
        .i_br    (r_rd_data.r),
        .i_tag   ({r_ci_idx, r_rd_idx}),
        .o_hit   (hit_v),
        .o_tag   (hit_tag),
        .o_busy  (pt_busy)
    );

    // hit list: keep pairs up to the cap, flag the rest
    always_ff @(posedge i_clk) begin
        if (hit_v && r_np < PAIR_CW'(PAIR_CAP)) begin
            pair_mem[r_np[PAIR_AW-1:0]] <= hit_tag;
        end
        r_prd <= pair_mem[r_k[PAIR_AW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_frame_end) begin
                    n_state = (cnt_next < CNT_W'(2)) ? ST_DRAIN : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!r_piv && (r_jj + 1'b1 >= r_n) && (CNT_W'(r_ii) + CNT_W'(2) >= r_n)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_v && !pt_busy) begin
                    n_state = (r_np == '0) ? ST_NOHIT : ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: n_state = ST_EMIT_A;
            ST_EMIT_A: begin
                if (out_free) n_state = ST_EMIT_B;
            end
            ST_EMIT_B: begin
                if (out_free) n_state = last_pair ? ST_IDLE : ST_EMIT_RD;
            end
            ST_NOHIT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mask      <= '0;
            r_count     <= '0;
            r_n         <= '0;
            r_ii        <= '0;
            r_jj        <= '0;
            r_piv       <= 1'b1;
            r_np        <= '0;
            r_drop_flag <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_mask <= i_cfg_wr_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_count <= i_frame_end ? '0 : cnt_next;
                        if (i_frame_end) begin
                            r_n         <= cnt_next;
                            r_ii        <= '0;
                            r_piv       <= 1'b1;
                            r_np        <= '0;
                            r_drop_flag <= 1'b0;
                            r_k         <= '0;
                        end
                    end
                end
                ST_CHECK: begin
                    if (r_piv) begin
                        r_piv <= 1'b0;
                        r_jj  <= CNT_W'(r_ii) + 1'b1;
                    end else if (r_jj + 1'b1 < r_n) begin
                        r_jj <= r_jj + 1'b1;
                    end else begin
                        r_ii  <= r_ii + 1'b1;
                        r_piv <= 1'b1;
                    end
                end
                ST_EMIT_B: begin
                    if (out_free) r_k <= r_k + 1'b1;
                end
                default: ;
            endcase
            if (hit_v) begin
                if (r_np < PAIR_CW'(PAIR_CAP)) r_np <= r_np + 1'b1;
                else r_drop_flag <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= (r_state == ST_EMIT_A) || (r_state == ST_EMIT_B) ||
                        (r_state == ST_NOHIT);
        end
        if (out_free) begin
            case (r_state)
                ST_EMIT_A: begin
                    r_self  <= r_prd[TAG_W-1:IDX_W];
                    r_other <= r_prd[IDX_W-1:0];
                    r_ohit  <= 1'b1;
                    r_odrop <= r_drop_flag;
                    r_olast <= 1'b0;
                end
                ST_EMIT_B: begin
                    r_self  <= r_prd[IDX_W-1:0];
                    r_other <= r_prd[TAG_W-1:IDX_W];
                    r_ohit  <= 1'b1;
                    r_odrop <= r_drop_flag;
                    r_olast <= last_pair;
                end
                ST_NOHIT: begin
                    r_self  <= '0;
                    r_other <= '0;
                    r_ohit  <= 1'b0;
                    r_odrop <= r_drop_flag;
                    r_olast <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign self_ext      = {{OUT_IDX_W{1'b0}}, r_self};
    assign other_ext     = {{OUT_IDX_W{1'b0}}, r_other};
    assign o_out_valid   = r_ovalid;
    assign o_self_index  = self_ext[OUT_IDX_W-1:0];
    assign o_other_index = other_ext[OUT_IDX_W-1:0];
    assign o_hit         = r_ohit;
    assign o_dropped     = r_odrop;
    assign o_last        = r_olast;

endmodule

// ===== test/pairwise_circle_collision_test.sv =====
`timescale 1ns / 1ps

module pairwise_circle_collision_test
    import pcc_pkg::*;
();

    localparam int MAX_CIRCLES  = 64;
    localparam int LAYERS       = 3;
    localparam int COORD_W      = 16;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 150;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [LAYERS*LAYERS-1:0] MASK_NONE = '0;
    localparam logic [LAYERS*LAYERS-1:0] MASK_ALL  = '1;
    localparam logic [LAYERS*LAYERS-1:0] MASK_SAME = 9'h111;
    // only an earlier layer 0 against a later layer 1
    localparam logic [LAYERS*LAYERS-1:0] MASK_0_THEN_1 = 9'(1) << (0 * LAYERS + 1);

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [RADIUS_W-1:0]       r;
        logic [LAYER_W-1:0]        layer;
    } t_circle;

    typedef struct {
        logic [OUT_IDX_W-1:0] self_idx;
        logic [OUT_IDX_W-1:0] other_idx;
        logic                 hit;
        logic                 dropped;
        logic                 last;
    } t_contact;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [LAYERS*LAYERS-1:0] i_cfg_wr_data = '0;
    logic i_in_valid = 1'b0;
    logic signed [COORD_W-1:0] i_center_x = '0;
    logic signed [COORD_W-1:0] i_center_y = '0;
    logic [RADIUS_W-1:0] i_radius = '0;
    logic [LAYER_W-1:0] i_layer = '0;
    logic i_frame_end = 1'b0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    logic [OUT_IDX_W-1:0] o_self_index;
    logic [OUT_IDX_W-1:0] o_other_index;
    logic o_hit;
    logic o_dropped;
    logic o_last;

    t_circle stored_circles[MAX_CIRCLES];
    int loaded_circles = 0;
    logic [LAYERS*LAYERS-1:0] layer_enable = MASK_NONE;
    t_contact expected_contacts[$];

    bit gaps_on = 1'b1;
    int stall_hold = 0;
    int cycle_count = 0;
    int error_count = 0;
    int circles_sent = 0;
    int random_circles = 0;
    int beats_checked = 0;
    int frames_checked = 0;
    int hit_beats = 0;
    int dropped_frames = 0;

    pairwise_circle_collision #(
        .MAX_CIRCLES(MAX_CIRCLES),
        .NUM_LAYERS (LAYERS),
        .COORD_BITS (COORD_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_layer      (i_layer),
        .i_frame_end  (i_frame_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_self_index (o_self_index),
        .o_other_index(o_other_index),
        .o_hit        (o_hit),
        .o_dropped    (o_dropped),
        .o_last       (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_contacts.size());
            $display("FAIL pairwise_circle_collision");
            $finish;
        end
    end

    // Hold off the result channel for a counted stretch when asked, else stall at random.
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold = stall_hold - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= gaps_on && ($urandom_range(0, 99) < 27);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : check_results
        t_contact want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_contacts.size() == 0) begin
                report_mismatch("unexpected result beat, self_index", o_self_index, 0);
            end else begin
                want = expected_contacts.pop_front();
                check_field("self_index", o_self_index, want.self_idx);
                check_field("other_index", o_other_index, want.other_idx);
                check_field("hit", o_hit, want.hit);
                check_field("dropped", o_dropped, want.dropped);
                check_field("last", o_last, want.last);
                beats_checked++;
                if (want.hit)
                    hit_beats++;
                if (want.last) begin
                    frames_checked++;
                    if (want.dropped)
                        dropped_frames++;
                end
            end
        end
    end

    // Test all stored pairs in load order and queue the contact beats of the frame.
    function automatic void predict_contacts();
        t_contact frame_beats[$];
        t_contact beat;
        bit overflow;
        longint dx, dy, rs;
        int la, lb;
        overflow = 1'b0;
        for (int i = 0; i < loaded_circles; i++) begin
            for (int j = i + 1; j < loaded_circles; j++) begin
                la = stored_circles[i].layer;
                lb = stored_circles[j].layer;
                if (la >= LAYERS || lb >= LAYERS)
                    continue;
                if (!layer_enable[la * LAYERS + lb])
                    continue;
                dx = longint'(stored_circles[i].x) - longint'(stored_circles[j].x);
                dy = longint'(stored_circles[i].y) - longint'(stored_circles[j].y);
                rs = longint'(stored_circles[i].r) + longint'(stored_circles[j].r);
                if (dx * dx + dy * dy >= rs * rs)
                    continue;
                if (frame_beats.size() + 2 > RESULT_CAP) begin
                    overflow = 1'b1;
                    continue;
                end
                beat = '{OUT_IDX_W'(i), OUT_IDX_W'(j), 1'b1, 1'b0, 1'b0};
                frame_beats.push_back(beat);
                beat = '{OUT_IDX_W'(j), OUT_IDX_W'(i), 1'b1, 1'b0, 1'b0};
                frame_beats.push_back(beat);
            end
        end
        if (frame_beats.size() == 0) begin
            beat = '{'0, '0, 1'b0, 1'b0, 1'b0};
            frame_beats.push_back(beat);
        end
        foreach (frame_beats[k])
            frame_beats[k].dropped = overflow;
        frame_beats[frame_beats.size() - 1].last = 1'b1;
        foreach (frame_beats[k])
            expected_contacts.push_back(frame_beats[k]);
        loaded_circles = 0;
    endfunction

    task automatic send_circle(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic [RADIUS_W-1:0] r,
                               input logic [LAYER_W-1:0] lay,
                               input bit fe);
        while (gaps_on && $urandom_range(0, 99) < 27) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_center_x  <= x;
        i_center_y  <= y;
        i_radius    <= r;
        i_layer     <= lay;
        i_frame_end <= fe;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
        // circles past the store size are dropped by the block
        if (loaded_circles < MAX_CIRCLES) begin
            stored_circles[loaded_circles] = '{x, y, r, lay};
            loaded_circles++;
        end
        circles_sent++;
        if (fe)
            predict_contacts();
    endtask

    // Send one frame of circles scattered around a random point; a few are pure noise.
    task automatic send_cluster(input int count, input int spread);
        int base_x, base_y;
        logic signed [COORD_W-1:0] x, y;
        logic [RADIUS_W-1:0] r;
        logic [LAYER_W-1:0] lay;
        base_x = $urandom;
        base_y = $urandom;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
                r = RADIUS_W'($urandom);
            end else begin
                x = COORD_W'(base_x + int'($urandom_range(0, 2 * spread)) - spread);
                y = COORD_W'(base_y + int'($urandom_range(0, 2 * spread)) - spread);
                r = RADIUS_W'($urandom_range(0, spread));
            end
            lay = ($urandom_range(0, 9) == 0) ? LAYER_W'(3) : LAYER_W'($urandom_range(0, 2));
            send_circle(x, y, r, lay, k == count - 1);
        end
    endtask

    // Drop valid, wait for every expected beat, then let the block settle.
    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_contacts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_layer_mask(input logic [LAYERS*LAYERS-1:0] value);
        drain_block();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        layer_enable = value;
    endtask

    // Mask is still at its reset value: overlapping circles give the no-hit beat.
    task automatic test_reset_mask();
        send_circle(0, 0, 10, 0, 1'b0);
        send_circle(5, 5, 10, 0, 1'b1);
        send_circle(7, -7, 3, 1, 1'b1);
    endtask

    task automatic test_extremes();
        write_layer_mask(MASK_ALL);
        send_circle(-32768, -32768, 16'hFFFF, 0, 1'b0);
        send_circle(32767, 32767, 16'hFFFF, 2, 1'b0);
        // layer 3 is outside the matrix and never tested
        send_circle(32767, -32768, 16'hFFFF, 3, 1'b1);
        // exact touching is not a collision; coincident zero radii are not either
        send_circle(0, 0, 2, 1, 1'b0);
        send_circle(3, 4, 3, 1, 1'b0);
        send_circle(-20, 0, 0, 0, 1'b0);
        send_circle(-20, 0, 0, 0, 1'b0);
        send_circle(10, 0, 5, 2, 1'b0);
        send_circle(16, 0, 2, 2, 1'b1);
    endtask

    task automatic test_layer_order();
        write_layer_mask(MASK_0_THEN_1);
        send_circle(0, 0, 10, 0, 1'b0);
        send_circle(1, 1, 10, 1, 1'b0);
        send_circle(500, 500, 10, 1, 1'b0);
        send_circle(501, 501, 10, 0, 1'b1);
    endtask

    // Nine stacked circles give 36 hits, more than the result cap holds.
    task automatic test_result_cap();
        write_layer_mask(MASK_ALL);
        for (int k = 0; k < 9; k++)
            send_circle(COORD_W'(-100 + k), 40, 50, LAYER_W'(k % LAYERS), k == 8);
    endtask

    task automatic test_store_full();
        write_layer_mask(MASK_ALL);
        send_cluster(MAX_CIRCLES + 2, 300);
    endtask

    task automatic test_backpressure();
        write_layer_mask(MASK_ALL);
        @(posedge i_clk);
        stall_hold = HOLD_CYCLES;
        send_cluster(12, 200);
        send_cluster(6, 200);
        send_cluster(3, 200);
    endtask

    task automatic test_random_frames();
        int phase;
        int size;
        logic [LAYERS*LAYERS-1:0] mask;
        phase = 0;
        while (random_circles < RANDOM_ITEMS) begin
            case (phase % 6)
                0: mask = MASK_ALL;
                1: mask = MASK_SAME;
                3: mask = MASK_NONE;
                default: mask = (LAYERS*LAYERS)'($urandom);
            endcase
            write_layer_mask(mask);
            // one phase runs with no gaps on either side
            gaps_on = (phase != 2);
            for (int f = $urandom_range(4, 8); f > 0; f--) begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 8);
                send_cluster(size, $urandom_range(4, 2000));
                random_circles += size;
            end
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_mask();
        test_extremes();
        test_layer_order();
        test_result_cap();
        test_store_full();
        test_backpressure();
        test_random_frames();
        drain_block();

        $display("sent %0d circles; checked %0d frames, %0d result beats (%0d hits)",
                 circles_sent, frames_checked, beats_checked, hit_beats);
        $display("covered layer masks, exact touching, full store, %0d capped frames, long hold",
                 dropped_frames);
        if (error_count == 0)
            $display("PASS pairwise_circle_collision");
        else
            $display("FAIL pairwise_circle_collision");
        $finish;
    end

endmodule

// ===== files.f =====
src/pcc_pkg.sv
src/pcc_pair_test.sv
src/pairwise_circle_collision.sv
test/pairwise_circle_collision_test.sv
